// ----- design/lcd_text_glyph_writer_top_assert.svh -----
// Assertion macros for the checker of this block.
// LTGW_ASSERT expects signals named clk and arst_n, LTGW_ASSERT_ALWAYS only clk, in the scope where they are used.
`ifndef LCD_TEXT_GLYPH_WRITER_TOP_ASSERT_SVH
`define LCD_TEXT_GLYPH_WRITER_TOP_ASSERT_SVH

// Checked only while reset is released.
`define LTGW_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("ltgw assertion failed");

// Checked at every edge, reset included.
`define LTGW_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("ltgw assertion failed");

`endif

// ----- design/ltgw_pkg.sv -----
package ltgw_pkg;

	localparam int WRAP_COLUMN_DEF = 60;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int GLYPH_W = 6;
	localparam int BEATS = GLYPH_W + 2;
	localparam int BEAT_W = $clog2(BEATS);
	localparam int SLOT_W = 6;
	localparam int MAX_PAGE = 8;
	localparam int MAX_COL = 64;

	localparam logic [1:0] FUNC_PUT = 2'd0;
	localparam logic [1:0] FUNC_HOME = 2'd1;
	localparam logic [1:0] FUNC_DRAW = 2'd2;

	localparam logic [1:0] KIND_CMD = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] PAGE_CMD = 8'hB8;
	localparam logic [7:0] COL_CMD = 8'h40;

	localparam logic [SLOT_W-1:0] SLASH_SLOT = 6'd10;
	localparam logic [SLOT_W-1:0] ALPHA_BASE = 6'd11;
	localparam logic [SLOT_W-1:0] BLANK_SLOT = 6'd37;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] character;
		logic [7:0] col;
		logic [7:0] row;
	} ltgw_in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] lcd_byte;
		logic       error;
		logic       last;
	} ltgw_out_t;

	// One queued job: a full draw or a single status result.
	typedef struct packed {
		logic              draw;
		logic              error;
		logic [7:0]        page_cmd;
		logic [7:0]        col_cmd;
		logic [SLOT_W-1:0] slot;
	} ltgw_job_t;

	// Digits take slots 0 to 9, slash 10, letters from ALPHA_BASE, blank last.
	function automatic logic [SLOT_W-1:0] pick_slot(input logic [7:0] ch,
		input logic allow_slash);
		logic [SLOT_W-1:0] s;
		s = BLANK_SLOT;
		if (ch inside {["0":"9"]}) begin
			s = SLOT_W'(ch - 8'h30);
		end else if (allow_slash && ch == 8'h2F) begin
			s = SLASH_SLOT;
		end else if (ch inside {["A":"Z"]}) begin
			s = ALPHA_BASE + SLOT_W'(ch - 8'h41);
		end else if (ch inside {["a":"z"]}) begin
			s = ALPHA_BASE + SLOT_W'(ch - 8'h61);
		end
		return s;
	endfunction

	// Glyph columns, leftmost column in the top byte.
	function automatic logic [7:0] glyph_byte(input logic [SLOT_W-1:0] slot,
		input logic [BEAT_W-1:0] idx);
		logic [47:0] r;
		logic [7:0]  b;
		case (slot)
			6'd0: r = 48'h003C42423C00;
			6'd1: r = 48'h0008047E0000;
			6'd2: r = 48'h0064524A4600;
			6'd3: r = 48'h004A4A4A3C00;
			6'd4: r = 48'h00302824_7E00;
			6'd5: r = 48'h004E4A4A3200;
			6'd6: r = 48'h007E4A4A7A00;
			6'd7: r = 48'h000272_0A0600;
			6'd8: r = 48'h007E4A4A7E00;
			6'd9: r = 48'h004E4A4A7E00;
			6'd10: r = 48'h006010080600;
			6'd11: r = 48'h007C12127C00;
			6'd12: r = 48'h007E4A4A6400;
			6'd13: r = 48'h003C42424200;
			6'd14: r = 48'h007E42423C00;
			6'd15: r = 48'h007E4A4A4A00;
			6'd16: r = 48'h007E0A0A0200;
			6'd17: r = 48'h003C42527200;
			6'd18: r = 48'h007E08087E00;
			6'd19: r = 48'h00007E000000;
			6'd20: r = 48'h0042422E0200;
			6'd21: r = 48'h007E08246200;
			6'd22: r = 48'h007E40404000;
			6'd23: r = 48'h007E0408047E;
			6'd24: r = 48'h007E0408107E;
			6'd25: r = 48'h007E42427E00;
			6'd26: r = 48'h007E12121E00;
			6'd27: r = 48'hFFFFFFFFFFFF;
			6'd28: r = 48'h007E12324C00;
			6'd29: r = 48'h004E4A4A7A00;
			6'd30: r = 48'h0002027E0202;
			6'd31: r = 48'h007E40407E00;
			6'd32: r = 48'h001E2040201E;
			6'd33: r = 48'h007E2010207E;
			6'd34: r = 48'h006618186600;
			6'd35: r = 48'h000204780402;
			6'd36: r = 48'h0062524A4600;
			default: r = 48'h000000000000;
		endcase
		case (idx)
			3'd0: b = r[47:40];
			3'd1: b = r[39:32];
			3'd2: b = r[31:24];
			3'd3: b = r[23:16];
			3'd4: b = r[15:8];
			3'd5: b = r[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ----- design/ltgw_front.sv -----
module ltgw_front import ltgw_pkg::*; #(
	parameter int WRAP_COLUMN = WRAP_COLUMN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ltgw_in_t  in_item,
	output logic      job_push,
	output ltgw_job_t job,
	input  logic      job_room
);

	localparam logic [6:0] WrapCol = 7'(WRAP_COLUMN);

	logic [5:0] cursor_col_q;
	logic [3:0] cursor_page_q;
	logic [5:0] col_d;
	logic [3:0] page_d;
	logic [6:0] adv_sum;
	logic       wrap;
	logic [3:0] lf_page;
	logic       accept;

	assign in_ready = job_room;
	assign accept = in_valid && job_room;
	assign job_push = accept;

	assign adv_sum = {1'b0, cursor_col_q} + 7'(GLYPH_W);
	assign wrap = adv_sum >= WrapCol;
	assign lf_page = {1'b0, cursor_page_q[2:0] + 3'd1};

	always_comb begin
		job = '0;
		job.slot = BLANK_SLOT;
		col_d = cursor_col_q;
		page_d = cursor_page_q;
		case (in_item.func)
			FUNC_PUT: begin
				if (in_item.character == CH_LF) begin
					if (wrap) begin
						col_d = '0;
						page_d = lf_page + 4'd1;
					end else begin
						col_d = adv_sum[5:0];
						page_d = lf_page;
					end
				end else if (in_item.character == CH_CR) begin
					col_d = '0;
				end else if (cursor_page_q > 4'(MAX_PAGE)) begin
					job.error = 1'b1;
				end else begin
					job.draw = 1'b1;
					job.page_cmd = PAGE_CMD | {4'b0, cursor_page_q};
					job.col_cmd = COL_CMD | {2'b0, cursor_col_q};
					job.slot = pick_slot(in_item.character, 1'b0);
					if (wrap) begin
						col_d = '0;
						page_d = cursor_page_q + 4'd1;
					end else begin
						col_d = adv_sum[5:0];
					end
				end
			end
			FUNC_HOME: begin
				col_d = '0;
				page_d = {1'b0, in_item.row[2:0]};
			end
			FUNC_DRAW: begin
				if (in_item.row > 8'(MAX_PAGE) || in_item.col > 8'(MAX_COL)) begin
					job.error = 1'b1;
				end else begin
					job.draw = 1'b1;
					job.page_cmd = PAGE_CMD | in_item.row;
					job.col_cmd = COL_CMD | in_item.col;
					job.slot = pick_slot(in_item.character, 1'b1);
				end
			end
			default: begin
				job.draw = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= '0;
			cursor_page_q <= '0;
		end else if (accept) begin
			cursor_col_q <= col_d;
			cursor_page_q <= page_d;
		end
	end

endmodule

// ----- design/ltgw_queue.sv -----
module ltgw_queue import ltgw_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ltgw_job_t push_job,
	output logic      room,
	input  logic      pop,
	output logic      head_valid,
	output ltgw_job_t head_job
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

	ltgw_job_t       slots_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     count_q;

	assign room = count_q != (AW+1)'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_job = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

endmodule

// ----- design/ltgw_back.sv -----
module ltgw_back import ltgw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  ltgw_job_t head_job,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output ltgw_out_t out_item
);

	localparam logic [BEAT_W-1:0] LastBeat = BEAT_W'(BEATS - 1);

	logic [BEAT_W-1:0] beat_q;
	logic [BEAT_W-1:0] glyph_idx;
	logic              out_valid_q;
	ltgw_out_t         out_q;
	ltgw_out_t         beat_d;
	logic              load;

	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop = load && beat_d.last;
	assign glyph_idx = beat_q - BEAT_W'(2);
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	always_comb begin
		beat_d = '0;
		if (!head_job.draw) begin
			beat_d.kind = KIND_STATUS;
			beat_d.error = head_job.error;
			beat_d.last = 1'b1;
		end else if (beat_q == '0) begin
			beat_d.kind = KIND_CMD;
			beat_d.lcd_byte = head_job.page_cmd;
		end else if (beat_q == BEAT_W'(1)) begin
			beat_d.kind = KIND_CMD;
			beat_d.lcd_byte = head_job.col_cmd;
		end else begin
			beat_d.kind = KIND_DATA;
			beat_d.lcd_byte = glyph_byte(head_job.slot, glyph_idx);
			beat_d.last = beat_q == LastBeat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				beat_q <= beat_d.last ? '0 : beat_q + BEAT_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= beat_d;
		end
	end

endmodule

// ----- design/lcd_text_glyph_writer_top.sv -----
// Channel   Handshake             Payload     Per item
// input     in_valid / in_ready   ltgw_in_t   one character code and function
// output    out_valid / out_ready ltgw_out_t  LCD command, data or status byte
//
// A drawn character gives 8 results, passed through the output register one after another;
// line feed, carriage return, home, rejects and unused codes give 1 result.
// The single output register, one byte per cycle unless out_ready stalls it, sets the rate;
// items are taken back to back while the job queue has room; the cursor moves at acceptance.
// Reset clears the cursor to column 0, page 0 and empties the queue.
// A stalled output holds its result; the queue then fills and in_ready drops.
module lcd_text_glyph_writer_top import ltgw_pkg::*; #(
	parameter int WRAP_COLUMN = WRAP_COLUMN_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ltgw_in_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output ltgw_out_t out_item
);

	logic      job_push;
	logic      job_room;
	ltgw_job_t job;
	logic      head_valid;
	ltgw_job_t head_job;
	logic      pop;

	ltgw_front #(
		.WRAP_COLUMN(WRAP_COLUMN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.job_push (job_push),
		.job      (job),
		.job_room (job_room)
	);

	ltgw_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (job),
		.room       (job_room),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	ltgw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

endmodule

// ----- design/ltgw_checker.sv -----
`include "lcd_text_glyph_writer_top_assert.svh"

module ltgw_checker import ltgw_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input ltgw_out_t out_item
);

	// No result may appear while reset is held.
	`LTGW_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |-> !out_valid)

	// A status result is a lone result carrying a zero byte.
	`LTGW_ASSERT(a_status_shape, out_valid && out_item.kind == KIND_STATUS |-> out_item.last && out_item.lcd_byte == 8'h00)

	// Errors are reported only through status results.
	`LTGW_ASSERT(a_error_is_status, out_valid && out_item.error |-> out_item.kind == KIND_STATUS)

	// A stalled result stays in place.
	`LTGW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item))

endmodule

bind lcd_text_glyph_writer_top ltgw_checker u_ltgw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

// ----- dv/lcd_text_glyph_writer_top_tb.sv -----
`timescale 1ns / 1ps

module lcd_text_glyph_writer_top_tb;
	import ltgw_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_PER_PHASE = 32;

	typedef struct packed {
		ltgw_in_t    stim;
		logic        typed;
		logic        exp_draw;
		logic        exp_err;
		logic [7:0]  exp_page_cmd;
		logic [7:0]  exp_col_cmd;
		logic [47:0] exp_glyph;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	ltgw_in_t  in_item;
	logic      out_valid;
	logic      out_ready = 1'b0;
	ltgw_out_t out_item;

	ltgw_out_t lcd_writes_due[$];
	logic [5:0] cur_col;
	logic [3:0] cur_page;
	int in_idle_pct;
	int out_stall_pct;
	int errors = 0;
	int quiet_cycles = 0;

	// Typed rows carry the expected writes; the others go through the predictor.
	dir_row_t directed_rows [0:24] = '{
		'{'{FUNC_PUT, "Q", 8'd0, 8'd0}, 1'b1, 1'b1, 1'b0, 8'hB8, 8'h40, 48'hFFFFFFFFFFFF},
		'{'{FUNC_DRAW, "/", 8'd64, 8'd8}, 1'b1, 1'b1, 1'b0, 8'hB8, 8'h40, 48'h006010080600},
		'{'{FUNC_DRAW, "A", 8'd65, 8'd0}, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_DRAW, "A", 8'd0, 8'd9}, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_DRAW, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_DRAW, 8'h00, 8'd0, 8'd0}, 1'b1, 1'b1, 1'b0, 8'hB8, 8'h40, 48'h0},
		'{'{FUNC_PUT, "/", 8'hFF, 8'hFF}, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_PUT, "z", 8'd0, 8'd0}, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_PUT, "9", 8'd0, 8'd0}, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_PUT, CH_LF, 8'd0, 8'd0}, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_PUT, CH_CR, 8'd0, 8'd0}, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_HOME, "A", 8'hFF, 8'hFF}, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_UNUSED, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_HOME, 8'd0, 8'd0, 8'd6}, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_PUT, CH_LF, 8'd0, 8'd0}, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_PUT, CH_LF, 8'd0, 8'd0}, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_PUT, CH_LF, 8'd0, 8'd0}, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_PUT, CH_LF, 8'd0, 8'd0}, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_PUT, CH_LF, 8'd0, 8'd0}, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_PUT, CH_LF, 8'd0, 8'd0}, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_PUT, CH_LF, 8'd0, 8'd0}, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_PUT, CH_LF, 8'd0, 8'd0}, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_PUT, CH_LF, 8'd0, 8'd0}, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_PUT, "M", 8'd0, 8'd0}, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0},
		'{'{FUNC_PUT, "W", 8'd0, 8'd0}, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 48'h0}
	};

	lcd_text_glyph_writer_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always #5 clk = ~clk;

	// Six glyph columns, leftmost column in the top byte.
	function automatic logic [47:0] font_columns(input logic [7:0] ch, input bit slash_ok);
		logic [7:0]  u;
		logic [47:0] g;
		u = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
		if (slash_ok && ch == "/")
			return 48'h006010080600;
		case (u)
			"0": g = 48'h003C42423C00;
			"1": g = 48'h0008047E0000;
			"2": g = 48'h0064524A4600;
			"3": g = 48'h004A4A4A3C00;
			"4": g = 48'h003028247E00;
			"5": g = 48'h004E4A4A3200;
			"6": g = 48'h007E4A4A7A00;
			"7": g = 48'h0002720A0600;
			"8": g = 48'h007E4A4A7E00;
			"9": g = 48'h004E4A4A7E00;
			"A": g = 48'h007C12127C00;
			"B": g = 48'h007E4A4A6400;
			"C": g = 48'h003C42424200;
			"D": g = 48'h007E42423C00;
			"E": g = 48'h007E4A4A4A00;
			"F": g = 48'h007E0A0A0200;
			"G": g = 48'h003C42527200;
			"H": g = 48'h007E08087E00;
			"I": g = 48'h00007E000000;
			"J": g = 48'h0042422E0200;
			"K": g = 48'h007E08246200;
			"L": g = 48'h007E40404000;
			"M": g = 48'h007E0408047E;
			"N": g = 48'h007E0408107E;
			"O": g = 48'h007E42427E00;
			"P": g = 48'h007E12121E00;
			"Q": g = 48'hFFFFFFFFFFFF;
			"R": g = 48'h007E12324C00;
			"S": g = 48'h004E4A4A7A00;
			"T": g = 48'h0002027E0202;
			"U": g = 48'h007E40407E00;
			"V": g = 48'h001E2040201E;
			"W": g = 48'h007E2010207E;
			"X": g = 48'h006618186600;
			"Y": g = 48'h000204780402;
			"Z": g = 48'h0062524A4600;
			default: g = 48'h0;
		endcase
		return g;
	endfunction

	function automatic void push_result(input logic [1:0] kind, input logic [7:0] b,
		input logic err, input logic last);
		ltgw_out_t r;
		r.kind = kind;
		r.lcd_byte = b;
		r.error = err;
		r.last = last;
		lcd_writes_due.push_back(r);
	endfunction

	function automatic void push_glyph_writes(input logic [7:0] page_cmd,
		input logic [7:0] col_cmd, input logic [47:0] g);
		push_result(KIND_CMD, page_cmd, 1'b0, 1'b0);
		push_result(KIND_CMD, col_cmd, 1'b0, 1'b0);
		for (int i = 0; i < GLYPH_W; i++)
			push_result(KIND_DATA, g[47 - 8 * i -: 8], 1'b0, i == GLYPH_W - 1);
	endfunction

	function automatic bit draw_glyph(input logic [47:0] g, input logic [7:0] x,
		input logic [7:0] y);
		if (y > MAX_PAGE || x > MAX_COL)
			return 1'b0;
		push_glyph_writes(PAGE_CMD | y, COL_CMD | x, g);
		return 1'b1;
	endfunction

	// The page wraps at 16 here, so a long run of text can walk off the panel.
	function automatic void advance_cursor();
		int x;
		x = cur_col + GLYPH_W;
		if (x >= WRAP_COLUMN_DEF) begin
			x = 0;
			cur_page = cur_page + 4'd1;
		end
		cur_col = 6'(x);
	endfunction

	function automatic void predict_lcd_writes(input ltgw_in_t it);
		case (it.func)
			FUNC_PUT: begin
				if (it.character == CH_LF) begin
					cur_page = (cur_page + 4'd1) & 4'd7;
					advance_cursor();
					push_result(KIND_STATUS, 8'h00, 1'b0, 1'b1);
				end else if (it.character == CH_CR) begin
					cur_col = '0;
					push_result(KIND_STATUS, 8'h00, 1'b0, 1'b1);
				end else if (draw_glyph(font_columns(it.character, 1'b0), {2'b00, cur_col},
					{4'b0000, cur_page})) begin
					advance_cursor();
				end else begin
					push_result(KIND_STATUS, 8'h00, 1'b1, 1'b1);
				end
			end
			FUNC_HOME: begin
				cur_page = {1'b0, it.row[2:0]};
				cur_col = '0;
				push_result(KIND_STATUS, 8'h00, 1'b0, 1'b1);
			end
			FUNC_DRAW: begin
				if (!draw_glyph(font_columns(it.character, 1'b1), it.col, it.row))
					push_result(KIND_STATUS, 8'h00, 1'b1, 1'b1);
			end
			default: push_result(KIND_STATUS, 8'h00, 1'b0, 1'b1);
		endcase
	endfunction

	function automatic logic [7:0] text_char();
		logic [7:0] c;
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5: c = 8'($urandom_range(8'h41, 8'h5A));
			6, 7, 8, 9: c = 8'($urandom_range(8'h61, 8'h7A));
			10, 11, 12: c = 8'($urandom_range(8'h30, 8'h39));
			13, 14: c = "/";
			15, 16: c = CH_LF;
			17: c = CH_CR;
			default: c = 8'($urandom);
		endcase
		return c;
	endfunction

	// A typed row replaces the predicted writes with the ones written in the table.
	task automatic send_item(input ltgw_in_t it, input dir_row_t typed_row = '0);
		int n_before;
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_before = lcd_writes_due.size();
		predict_lcd_writes(it);
		if (typed_row.typed) begin
			while (lcd_writes_due.size() > n_before)
				lcd_writes_due.delete(lcd_writes_due.size() - 1);
			if (typed_row.exp_draw)
				push_glyph_writes(typed_row.exp_page_cmd, typed_row.exp_col_cmd,
					typed_row.exp_glyph);
			else
				push_result(KIND_STATUS, 8'h00, typed_row.exp_err, 1'b1);
		end
	endtask

	task automatic wait_writes_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (lcd_writes_due.size() != 0);
	endtask

	// Mostly lines of text after a home, so the cursor wraps and overflows its pages.
	task automatic run_random(input int n_items);
		ltgw_in_t it;
		int sent;
		int burst;
		int pick;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			it.col = 8'($urandom);
			it.row = 8'($urandom);
			it.character = 8'($urandom);
			if (pick < 55) begin
				it.func = FUNC_HOME;
				send_item(it);
				burst = $urandom_range(3, 24);
				if (burst > n_items - sent - 1)
					burst = n_items - sent - 1;
				repeat (burst) begin
					it.func = FUNC_PUT;
					it.character = text_char();
					it.col = 8'($urandom);
					it.row = 8'($urandom);
					send_item(it);
				end
				sent += burst + 1;
			end else if (pick < 85) begin
				it.func = FUNC_DRAW;
				it.character = text_char();
				it.col = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(65, 255))
					: 8'($urandom_range(0, MAX_COL));
				it.row = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(9, 255))
					: 8'($urandom_range(0, MAX_PAGE));
				send_item(it);
				sent++;
			end else begin
				it.func = 2'($urandom_range(0, 3));
				send_item(it);
				sent++;
			end
		end
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= out_stall_pct);

	always @(posedge clk) begin
		ltgw_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (lcd_writes_due.size() == 0) begin
				$error("unexpected LCD write: kind %0d byte %02h", out_item.kind,
					out_item.lcd_byte);
				errors++;
			end else begin
				want = lcd_writes_due.pop_front();
				if (out_item.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, out_item.kind);
					errors++;
				end
				if (out_item.lcd_byte !== want.lcd_byte) begin
					$error("lcd_byte: expected %02h, got %02h", want.lcd_byte,
						out_item.lcd_byte);
					errors++;
				end
				if (out_item.error !== want.error) begin
					$error("error: expected %0d, got %0d", want.error, out_item.error);
					errors++;
				end
				if (out_item.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, out_item.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cur_col = '0;
		cur_page = '0;
		in_idle_pct = 7;
		out_stall_pct = 84;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].stim, directed_rows[i]);
		run_random(RANDOM_PER_PHASE);

		wait_writes_drained();
		in_idle_pct = 84;
		out_stall_pct = 7;
		run_random(RANDOM_PER_PHASE);

		wait_writes_drained();
		in_idle_pct = 0;
		out_stall_pct = 0;
		run_random(RANDOM_PER_PHASE);

		wait_writes_drained();
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
